/* hw/rtl/csrb_pkg.sv */
package csrb_pkg;

    localparam logic [31:0] FRAME_BASE_RESET = 32'h0600_0000;
    localparam int unsigned PIXEL_SHIFT = 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ROW  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] dest_row;
        logic signed [15:0] dest_col;
        logic signed [15:0] src_row;
        logic signed [15:0] src_col;
        logic signed [15:0] blit_height;
        logic signed [15:0] blit_width;
        logic [31:0]        image_base;
        logic [15:0]        image_stride;
    } t_req;

    typedef struct packed {
        logic        is_row;
        logic        draws;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  pixel_count;
        logic [7:0]  row_total;
        logic        last;
    } t_res;

    // Clipped request. Coordinates and sizes are only meaningful when vis is set.
    typedef struct packed {
        t_cmd               cmd;
        logic               vis;
        logic signed [17:0] sr;
        logic signed [17:0] sc;
        logic [15:0]        dr;
        logic [15:0]        dc;
        logic [15:0]        h;
        logic [15:0]        w;
        logic [31:0]        base;
        logic [15:0]        stride;
    } t_clip;

endpackage

/* hw/rtl/csrb_stream_if.sv */
interface csrb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/csrb_clip.sv */
module csrb_clip
    import csrb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 160
) (
    input  t_req  i_req,
    output t_clip o_clip
);

    localparam logic signed [17:0] SW = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SH = 18'(SCREEN_HEIGHT);

    always_comb begin
        logic signed [17:0] dr;
        logic signed [17:0] dc;
        logic signed [17:0] sr;
        logic signed [17:0] sc;
        logic signed [17:0] h;
        logic signed [17:0] w;
        logic               vis;

        dr = 18'(i_req.dest_row);
        dc = 18'(i_req.dest_col);
        sr = 18'(i_req.src_row);
        sc = 18'(i_req.src_col);
        h  = 18'(i_req.blit_height);
        w  = 18'(i_req.blit_width);
        vis = (h > 18'sd0) && (w > 18'sd0);

        // Left edge: skip the overhanging source columns.
        if (dc < 18'sd0) begin
            if (w + dc > 18'sd0) begin
                sc = sc - dc;
                w  = w + dc;
                dc = 18'sd0;
            end else begin
                vis = 1'b0;
            end
        end
        if (dc + w > SW) begin
            if (dc >= SW) begin
                vis = 1'b0;
            end else begin
                w = SW - dc;
            end
        end
        if (dr < 18'sd0) begin
            if (h + dr > 18'sd0) begin
                sr = sr - dr;
                h  = h + dr;
                dr = 18'sd0;
            end else begin
                vis = 1'b0;
            end
        end
        if (dr + h > SH) begin
            if (dr >= SH) begin
                vis = 1'b0;
            end else begin
                h = SH - dr;
            end
        end

        o_clip.cmd    = i_req.cmd;
        o_clip.vis    = vis;
        o_clip.sr     = sr;
        o_clip.sc     = sc;
        o_clip.dr     = dr[15:0];
        o_clip.dc     = dc[15:0];
        o_clip.h      = h[15:0];
        o_clip.w      = w[15:0];
        o_clip.base   = i_req.image_base;
        o_clip.stride = i_req.image_stride;
    end

endmodule

/* hw/rtl/clipped_sprite_row_blit.sv */
// A clipped request is held in the clip stage; the address stage registers its result.
// Throughput: one request per cycle unless o_res stalls; the clip stage and the address
// stage each hold one request, and the address stage alone reads and updates the blit state.
// Reset (i_rst_n low, synchronous): pipeline empty, no rows pending, frame base 0x6000000.
module clipped_sprite_row_blit
    import csrb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 160
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    csrb_stream_if.sink           i_req,
    csrb_stream_if.source         o_res
);

    localparam int RW = $clog2(SCREEN_HEIGHT + 1);
    localparam int CW = $clog2(SCREEN_WIDTH + 1);
    localparam logic [31:0] DST_STEP = 32'(SCREEN_WIDTH) << PIXEL_SHIFT;

    t_clip       clip;

    logic        r_a_valid;
    t_clip       r_a;
    logic        r_o_valid;
    t_res        r_res;
    t_res        n_res;
    logic [31:0] r_frame_base;

    logic          r_busy;
    logic [RW-1:0] r_rows_left;
    logic [CW-1:0] r_row_width;
    logic [31:0]   r_src_row_addr;
    logic [31:0]   r_dst_row_addr;
    logic [31:0]   r_src_step;

    logic          n_busy;
    logic [RW-1:0] n_rows_left;
    logic [CW-1:0] n_row_width;
    logic [31:0]   n_src_row_addr;
    logic [31:0]   n_dst_row_addr;
    logic [31:0]   n_src_step;

    logic        adv_b;
    logic        adv_a;

    csrb_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .i_req  (i_req.payload),
        .o_clip (clip)
    );

    assign adv_b       = !r_o_valid || o_res.ready;
    assign adv_a       = !r_a_valid || adv_b;
    assign i_req.ready = adv_a;
    assign o_res.valid = r_o_valid;
    assign o_res.payload = r_res;

    always_comb begin
        logic [31:0] src_prod;
        logic [31:0] src_first;
        logic [31:0] dst_first;
        logic [31:0] width32;

        src_prod  = 32'(r_a.sr) * {16'd0, r_a.stride};
        src_first = r_a.base + ((src_prod + 32'(r_a.sc)) << PIXEL_SHIFT);
        dst_first = r_frame_base +
            (((32'(r_a.dr) * 32'(SCREEN_WIDTH)) + 32'(r_a.dc)) << PIXEL_SHIFT);
        width32   = 32'(r_row_width);

        n_busy         = r_busy;
        n_rows_left    = r_rows_left;
        n_row_width    = r_row_width;
        n_src_row_addr = r_src_row_addr;
        n_dst_row_addr = r_dst_row_addr;
        n_src_step     = r_src_step;
        n_res          = '0;

        case (r_a.cmd)
            CMD_LOAD: begin
                if (r_a.vis) begin
                    n_busy            = 1'b1;
                    n_rows_left       = r_a.h[RW-1:0];
                    n_row_width       = r_a.w[CW-1:0];
                    n_src_step        = {15'd0, r_a.stride, 1'b0};
                    n_src_row_addr    = src_first;
                    n_dst_row_addr    = dst_first;
                    n_res.draws       = 1'b1;
                    n_res.src_addr    = src_first;
                    n_res.dst_addr    = dst_first;
                    n_res.pixel_count = r_a.w[7:0];
                    n_res.row_total   = r_a.h[7:0];
                end else begin
                    n_busy      = 1'b0;
                    n_rows_left = '0;
                end
            end
            CMD_ROW: begin
                if (!r_busy || r_rows_left == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_res.is_row      = 1'b1;
                    n_res.src_addr    = r_src_row_addr;
                    n_res.dst_addr    = r_dst_row_addr;
                    n_res.pixel_count = width32[7:0];
                    n_res.last        = (r_rows_left == RW'(1));
                    n_rows_left       = r_rows_left - RW'(1);
                    n_src_row_addr    = r_src_row_addr + r_src_step;
                    n_dst_row_addr    = r_dst_row_addr + DST_STEP;
                    n_busy            = (r_rows_left != RW'(1));
                end
            end
            default: begin
                n_busy = r_busy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
            r_frame_base   <= FRAME_BASE_RESET;
            r_busy         <= 1'b0;
            r_rows_left    <= '0;
            r_row_width    <= '0;
            r_src_row_addr <= '0;
            r_dst_row_addr <= '0;
            r_src_step     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_base <= i_cfg_wdata;
            end
            if (adv_a) begin
                r_a_valid <= i_req.valid;
            end
            if (adv_b) begin
                r_o_valid <= r_a_valid;
            end
            // Blit state moves only when a request leaves the address stage.
            if (adv_b && r_a_valid) begin
                r_busy         <= n_busy;
                r_rows_left    <= n_rows_left;
                r_row_width    <= n_row_width;
                r_src_row_addr <= n_src_row_addr;
                r_dst_row_addr <= n_dst_row_addr;
                r_src_step     <= n_src_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_req.valid) begin
            r_a <= clip;
        end
        if (adv_b && r_a_valid) begin
            r_res <= n_res;
        end
    end

endmodule
